/* hdl/hmf_pkg.sv */
// Shared constants and types of the hybrid median image filter.
`timescale 1ns / 1ps
package hmf_pkg;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_RADIUS = 4;
  localparam int unsigned LANES      = 2 * MAX_RADIUS;
  localparam int unsigned WIN        = LANES + 1;
  localparam int unsigned NSET       = 4 * MAX_RADIUS + 1;
  localparam int unsigned MED_RANK   = NSET / 2;
  localparam int unsigned FIFO_DEPTH = 8192;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned COL_AW     = $clog2(MAX_WIDTH);
  localparam int unsigned RAD_W      = $clog2(MAX_RADIUS + 1);

  localparam logic MODE_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_IMAGE_WIDTH   = 2'd1,
    CFG_IMAGE_HEIGHT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic pix;
    logic emit;
    logic border;
    logic fend;
  } ctl_t;
endpackage

/* hdl/hmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* hdl/hmf_median.sv */
// Two-stage rank-based median of a fixed-size pixel set.
`timescale 1ns / 1ps
module hmf_median (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  hmf_pkg::pix_t [hmf_pkg::NSET-1:0]   vals_i,
  output hmf_pkg::pix_t                       med_o
);
  hmf_pkg::pix_t [hmf_pkg::NSET-1:0]       vals_q;
  logic [hmf_pkg::NSET-1:0][hmf_pkg::NSET-1:0] lt_q, lt_d;
  hmf_pkg::pix_t                           med_q, med_d;

  always_comb begin
    for (int i = 0; i < hmf_pkg::NSET; i++) begin
      for (int j = 0; j < hmf_pkg::NSET; j++) begin
        lt_d[i][j] = (vals_i[j] < vals_i[i]) || ((vals_i[j] == vals_i[i]) && (j < i));
      end
    end
  end

  always_comb begin
    med_d = '0;
    for (int i = 0; i < hmf_pkg::NSET; i++) begin
      if ($countones(lt_q[i]) == hmf_pkg::MED_RANK) begin
        med_d = med_d | vals_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vals_q <= vals_i;
      lt_q   <= lt_d;
      med_q  <= med_d;
    end
  end

  assign med_o = med_q;
endmodule

/* hdl/hybrid_median_image_filter.sv */
// Top level of the streaming hybrid median image filter.
//
// Pixels enter in raster order on the input channel (in_valid_i/in_ready_o);
// mode_i = 0 carries a pixel, mode_i = 1 is a drain transaction that flushes
// one pending border pixel. Filtered pixels leave in raster order on the
// output channel (out_valid_o/out_ready_i) with frame_end_o on the last one.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write them only while idle, the block itself does not enforce it. A write
// to any of the three defined registers restarts the frame and drops pending
// pixels. Throughput: one transaction per cycle while the receiver does not
// stall the output. out_valid_o follows the accepting edge through the
// line-store read, the window shift, the two-stage rank median and the
// final three-way median register. The pixel itself lags R*W+R transactions
// behind its input. A stalled receiver holds the whole pipeline; in_ready_o
// drops only while a result waits and out_ready_i is low.
// Reset clears control state at once; line store and window hold no valid
// data until written and need no clearing pass.
`timescale 1ns / 1ps
module hybrid_median_image_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          mode_i,
  input  logic [15:0]   pixel_in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [15:0]   pixel_out_o,
  output logic          frame_end_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [12:0]   cfg_data_i
);
  localparam int unsigned LW = hmf_pkg::LANES * hmf_pkg::PIX_W;

  logic [3:0]  wl_q;
  logic [10:0] wid_q;
  logic [12:0] hgt_q;
  logic [hmf_pkg::COL_AW-1:0]  in_col_q, out_col_q;
  logic [12:0] out_row_q, pend_q;
  logic [hmf_pkg::FIFO_AW-1:0] head_q, tail_q;

  logic [3:0]  len;
  logic [hmf_pkg::RAD_W-1:0] rad;
  logic [10:0] w_eff;
  logic [12:0] h_eff, lag;
  logic        adv, accept, is_pix, border, fend, emit;

  hmf_pkg::ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q;
  hmf_pkg::pix_t s1_pixel_q, s2_centre_q, s3_centre_q, s4_centre_q;
  logic [hmf_pkg::COL_AW-1:0] s1_col_q;
  logic          s1_fwd_q;
  logic [LW-1:0] s1_fwd_data_q;

  logic [LW-1:0] line_rdata, line_wdata;
  logic          line_we;
  hmf_pkg::pix_t [hmf_pkg::LANES-1:0] lanes;
  hmf_pkg::pix_t [hmf_pkg::WIN-1:0]   colvec;
  hmf_pkg::pix_t [hmf_pkg::WIN-1:0][hmf_pkg::WIN-1:0] win_q;
  hmf_pkg::pix_t fifo_rdata;

  hmf_pkg::pix_t [hmf_pkg::NSET-1:0] plus_v, cross_v;
  hmf_pkg::pix_t plus_med, cross_med, lo, hi, med3;

  logic          out_valid_q, out_fend_q;
  hmf_pkg::pix_t out_pixel_q;

  always_comb begin
    len = (wl_q < 4'd3) ? 4'd3 : wl_q;
    if (!len[0]) begin
      len = len + 4'd1;
    end
    rad = (len[3:1] > 3'(hmf_pkg::MAX_RADIUS)) ? 3'(hmf_pkg::MAX_RADIUS) : len[3:1];
    if (wid_q == 11'd0) begin
      w_eff = 11'd1;
    end else if (wid_q > 11'(hmf_pkg::MAX_WIDTH)) begin
      w_eff = 11'(hmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = wid_q;
    end
    h_eff = (hgt_q == 13'd0) ? 13'd1 : hgt_q;
    lag   = 13'(rad) * 13'(w_eff) + 13'(rad);
  end

  assign adv    = !out_valid_q || out_ready_i;
  assign accept = in_valid_i && adv;
  assign is_pix = (mode_i != hmf_pkg::MODE_DRAIN);

  assign border = !((out_col_q >= 10'(rad)) &&
                    ((12'(out_col_q) + 12'(rad)) < 12'(w_eff)) &&
                    (out_row_q >= 13'(rad)) &&
                    ((14'(out_row_q) + 14'(rad)) < 14'(h_eff)));
  assign fend   = ((14'(out_row_q) + 14'd1) == 14'(h_eff)) &&
                  ((11'(out_col_q) + 11'd1) == w_eff);
  assign emit   = accept && (is_pix ? ((14'(pend_q) + 14'd1) > 14'(lag))
                                    : ((pend_q != 13'd0) && border));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q      <= 4'd3;
      wid_q     <= 11'd1024;
      hgt_q     <= 13'd1024;
      in_col_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hmf_pkg::CFG_WINDOW_LENGTH: wl_q  <= cfg_data_i[3:0];
        hmf_pkg::CFG_IMAGE_WIDTH:   wid_q <= cfg_data_i[10:0];
        hmf_pkg::CFG_IMAGE_HEIGHT:  hgt_q <= cfg_data_i;
        default: ;
      endcase
      if (cfg_idx_i inside {hmf_pkg::CFG_WINDOW_LENGTH, hmf_pkg::CFG_IMAGE_WIDTH,
                            hmf_pkg::CFG_IMAGE_HEIGHT}) begin
        in_col_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        pend_q    <= '0;
        head_q    <= tail_q;
      end
    end else if (accept) begin
      if (is_pix) begin
        tail_q   <= tail_q + 1'b1;
        in_col_q <= ((11'(in_col_q) + 11'd1) >= w_eff) ? '0 : in_col_q + 1'b1;
      end
      pend_q <= pend_q + 13'(is_pix) - 13'(emit);
      if (emit) begin
        head_q <= head_q + 1'b1;
        if ((11'(out_col_q) + 11'd1) >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= ((14'(out_row_q) + 14'd1) >= 14'(h_eff)) ? 13'd0 : out_row_q + 13'd1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  hmf_ram #(.WIDTH(hmf_pkg::PIX_W), .DEPTH(hmf_pkg::FIFO_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_pix),
    .waddr_i (tail_q),
    .wdata_i (pixel_in_i),
    .re_i    (emit),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  assign line_we    = adv && s1_ctl_q.valid && s1_ctl_q.pix;
  assign lanes      = s1_fwd_q ? s1_fwd_data_q : line_rdata;
  assign line_wdata = {lanes[hmf_pkg::LANES-2:0], s1_pixel_q};
  assign colvec     = {lanes, s1_pixel_q};

  hmf_ram #(.WIDTH(LW), .DEPTH(hmf_pkg::MAX_WIDTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_col_q),
    .wdata_i (line_wdata),
    .re_i    (accept && is_pix),
    .raddr_i (in_col_q),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q    <= '0;
      s2_ctl_q    <= '0;
      s3_ctl_q    <= '0;
      s4_ctl_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_ctl_q    <= '{valid: accept, pix: is_pix, emit: emit, border: border, fend: fend};
      s2_ctl_q    <= s1_ctl_q;
      s3_ctl_q    <= s2_ctl_q;
      s4_ctl_q    <= s3_ctl_q;
      out_valid_q <= s4_ctl_q.valid && s4_ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pixel_q    <= pixel_in_i;
      s1_col_q      <= in_col_q;
      s1_fwd_q      <= line_we && (s1_col_q == in_col_q);
      s1_fwd_data_q <= line_wdata;
      s2_centre_q   <= fifo_rdata;
      s3_centre_q   <= s2_centre_q;
      s4_centre_q   <= s3_centre_q;
      out_pixel_q   <= s4_ctl_q.border ? s4_centre_q : med3;
      out_fend_q    <= s4_ctl_q.fend;
    end
    if (line_we) begin
      win_q <= {win_q[hmf_pkg::WIN-2:0], colvec};
    end
  end

  always_comb begin
    logic [3:0] rr, ip, im;
    int unsigned b;
    rr = 4'(rad);
    plus_v[0]  = win_q[rr][rr];
    cross_v[0] = win_q[rr][rr];
    for (int d = 1; d <= hmf_pkg::MAX_RADIUS; d++) begin
      b  = 4 * d - 3;
      ip = rr + 4'(d);
      im = rr - 4'(d);
      if (d <= rad) begin
        plus_v[b]    = win_q[rr][ip];
        plus_v[b+1]  = win_q[ip][rr];
        plus_v[b+2]  = win_q[im][rr];
        plus_v[b+3]  = win_q[rr][im];
        cross_v[b]   = win_q[ip][ip];
        cross_v[b+1] = win_q[im][ip];
        cross_v[b+2] = win_q[ip][im];
        cross_v[b+3] = win_q[im][im];
      end else begin
        plus_v[b]    = '0;
        plus_v[b+1]  = '0;
        plus_v[b+2]  = '1;
        plus_v[b+3]  = '1;
        cross_v[b]   = '0;
        cross_v[b+1] = '0;
        cross_v[b+2] = '1;
        cross_v[b+3] = '1;
      end
    end
  end

  hmf_median u_plus_med (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vals_i (plus_v),
    .med_o  (plus_med)
  );

  hmf_median u_cross_med (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vals_i (cross_v),
    .med_o  (cross_med)
  );

  always_comb begin
    lo   = (plus_med < cross_med) ? plus_med : cross_med;
    hi   = (plus_med < cross_med) ? cross_med : plus_med;
    med3 = (hi < s4_centre_q) ? hi : s4_centre_q;
    med3 = (lo > med3) ? lo : med3;
  end

  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pixel_q;
  assign frame_end_o = out_fend_q;
endmodule

/* verif/tb_hybrid_median_image_filter.sv */
// Self-checking testbench of the hybrid median image filter with a built-in filter predictor.
`timescale 1ns / 1ps
module tb_hybrid_median_image_filter;
  localparam int unsigned RING_LEN   = hmf_pkg::WIN * hmf_pkg::MAX_WIDTH;
  localparam int unsigned PIPE_LAT   = 12;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam logic        MODE_PIXEL = 1'b0;

  typedef struct {
    hmf_pkg::pix_t pix;
    logic          fend;
  } out_pix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_PIXEL;
  logic [15:0] pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] pixel_out;
  logic        frame_end;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [12:0] cfg_data = '0;

  hybrid_median_image_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .pixel_in_i  (pixel_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_out_o (pixel_out),
    .frame_end_o (frame_end),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // filter state mirrored by the predictor
  hmf_pkg::pix_t img_ring [RING_LEN];
  int unsigned   wr_pos, out_col, out_row, pend_cnt;
  logic [3:0]    win_len;
  logic [10:0]   img_w;
  logic [12:0]   img_h;

  out_pix_t    exp_pix_q[$];
  int unsigned err_cnt;
  int unsigned burst_left;
  int unsigned rand_items;

  function automatic int unsigned radius();
    int unsigned len;
    len = (win_len < 3) ? 3 : win_len;
    if (len % 2 == 0) len++;
    return ((len - 1) / 2 > hmf_pkg::MAX_RADIUS) ? hmf_pkg::MAX_RADIUS : (len - 1) / 2;
  endfunction

  function automatic int unsigned frame_w();
    if (img_w == 0) return 1;
    return (img_w > hmf_pkg::MAX_WIDTH) ? hmf_pkg::MAX_WIDTH : img_w;
  endfunction

  function automatic int unsigned frame_h();
    return (img_h == 0) ? 1 : img_h;
  endfunction

  function automatic hmf_pkg::pix_t ring_at(int unsigned off);
    return img_ring[(wr_pos + RING_LEN - 1 - off) % RING_LEN];
  endfunction

  function automatic hmf_pkg::pix_t median_of(hmf_pkg::pix_t v[hmf_pkg::NSET], int unsigned n);
    hmf_pkg::pix_t t;
    int            j;
    for (int i = 1; i < n; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    return v[n/2];
  endfunction

  function automatic logic at_border();
    int unsigned r;
    r = radius();
    return !(out_col >= r && out_col + r < frame_w() && out_row >= r && out_row + r < frame_h());
  endfunction

  function automatic void emit_oldest();
    int unsigned   r, w, b, n;
    hmf_pkg::pix_t plus_set[hmf_pkg::NSET], diag_set[hmf_pkg::NSET], trio[hmf_pkg::NSET];
    out_pix_t      o;
    r = radius();
    w = frame_w();
    b = pend_cnt - 1;
    o.pix = ring_at(b);
    if (!at_border()) begin
      plus_set[0] = o.pix;
      diag_set[0] = o.pix;
      n = 1;
      for (int unsigned d = 1; d <= r; d++) begin
        plus_set[n]   = ring_at(b + d * w);
        diag_set[n]   = ring_at(b + d * w + d);
        plus_set[n+1] = ring_at(b + d);
        diag_set[n+1] = ring_at(b + d * w - d);
        plus_set[n+2] = ring_at(b - d);
        diag_set[n+2] = ring_at(b - d * w + d);
        plus_set[n+3] = ring_at(b - d * w);
        diag_set[n+3] = ring_at(b - d * w - d);
        n += 4;
      end
      trio[0] = median_of(plus_set, n);
      trio[1] = median_of(diag_set, n);
      trio[2] = o.pix;
      o.pix = median_of(trio, 3);
    end
    o.fend = (out_row == frame_h() - 1) && (out_col == w - 1);
    exp_pix_q.insert(exp_pix_q.size(), o);
    pend_cnt--;
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_row = (out_row + 1 >= frame_h()) ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
  endfunction

  function automatic void predict_filter(logic m, hmf_pkg::pix_t p);
    int unsigned lag;
    lag = radius() * frame_w() + radius();
    if (m == MODE_PIXEL) begin
      img_ring[wr_pos] = p;
      wr_pos = (wr_pos + 1 >= RING_LEN) ? 0 : wr_pos + 1;
      pend_cnt++;
      if (pend_cnt > lag) emit_oldest();
    end else if (pend_cnt > 0 && at_border()) begin
      emit_oldest();
    end
  endfunction

  function automatic hmf_pkg::pix_t rand_pix();
    case ($urandom_range(0, 3))
      0: return hmf_pkg::pix_t'($urandom_range(0, 7));
      1: return 16'hFFFF - hmf_pkg::pix_t'($urandom_range(0, 7));
      default: return hmf_pkg::pix_t'($urandom);
    endcase
  endfunction

  task automatic send_item(logic m, hmf_pkg::pix_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    mode     <= m;
    pixel_in <= p;
    do @(posedge clk_i); while (!in_ready);
    predict_filter(m, p);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_pix_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      hmf_pkg::CFG_WINDOW_LENGTH: win_len = val[3:0];
      hmf_pkg::CFG_IMAGE_WIDTH:   img_w = val[10:0];
      hmf_pkg::CFG_IMAGE_HEIGHT:  img_h = val;
      default: ;
    endcase
    if (idx != CFG_UNUSED) begin
      out_col  = 0;
      out_row  = 0;
      pend_cnt = 0;
    end
  endtask

  task automatic set_frame(int unsigned len, int unsigned w, int unsigned h);
    write_reg(hmf_pkg::CFG_WINDOW_LENGTH, 13'(len));
    write_reg(hmf_pkg::CFG_IMAGE_WIDTH, 13'(w));
    write_reg(hmf_pkg::CFG_IMAGE_HEIGHT, 13'(h));
  endtask

  task automatic send_frame(int unsigned noise_pct);
    for (int unsigned i = 0; i < frame_w() * frame_h(); i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(hmf_pkg::MODE_DRAIN, hmf_pkg::pix_t'($urandom));
      send_item(MODE_PIXEL, rand_pix());
    end
    while (pend_cnt > 0) send_item(hmf_pkg::MODE_DRAIN, hmf_pkg::pix_t'($urandom));
  endtask

  task automatic send_partial(int unsigned cnt);
    for (int unsigned i = 0; i < cnt; i++) send_item(MODE_PIXEL, rand_pix());
    while (pend_cnt > 0) send_item(hmf_pkg::MODE_DRAIN, '0);
  endtask

  task automatic test_directed();
    set_frame(3, 5, 5);
    send_item(hmf_pkg::MODE_DRAIN, 16'hFFFF);
    for (int unsigned i = 0; i < 25; i++)
      send_item(MODE_PIXEL, (i % 2 == 0) ? 16'h0000 : 16'hFFFF);
    while (pend_cnt > 0) send_item(hmf_pkg::MODE_DRAIN, 16'h0000);
    send_item(hmf_pkg::MODE_DRAIN, 16'h0000);
  endtask

  task automatic test_window_lengths();
    int unsigned lens[4] = '{0, 2, 4, 15};
    int unsigned wids[4] = '{4, 4, 6, 10};
    int unsigned hgts[4] = '{3, 3, 5, 9};
    foreach (lens[k]) begin
      set_frame(lens[k], wids[k], hgts[k]);
      send_frame(0);
    end
  endtask

  task automatic test_size_extremes();
    set_frame(3, 0, 0);
    send_frame(10);
    set_frame(5, 1, 7);
    send_frame(0);
    set_frame(7, 3, 12);
    send_frame(0);
    set_frame(3, 2047, 1);
    send_partial(30);
    set_frame(9, 1024, 9);
    send_partial(30);
    set_frame(3, 1, 4096);
    send_partial(20);
    set_frame(3, 4, 8191);
    for (int unsigned i = 0; i < 20; i++) send_item(MODE_PIXEL, rand_pix());
  endtask

  task automatic test_restart();
    set_frame(3, 5, 5);
    for (int unsigned i = 0; i < 12; i++) send_item(MODE_PIXEL, rand_pix());
    write_reg(CFG_UNUSED, 13'h1FFF);
    for (int unsigned i = 0; i < 13; i++) send_item(MODE_PIXEL, rand_pix());
    while (pend_cnt > 0) send_item(hmf_pkg::MODE_DRAIN, '0);
    for (int unsigned i = 0; i < 10; i++) send_item(MODE_PIXEL, rand_pix());
    write_reg(hmf_pkg::CFG_IMAGE_HEIGHT, 13'd5);
    send_frame(0);
  endtask

  task automatic test_random();
    int unsigned len, w, h, r;
    while (rand_items < 120) begin
      len = $urandom_range(0, 15);
      r = (len < 3) ? 1 : ((len > 9) ? 4 : len / 2);
      w = $urandom_range(2 * r + 1, 12);
      h = $urandom_range(2 * r + 1, 10);
      if ($urandom_range(0, 7) == 0) w = $urandom_range(1, 2 * r);
      set_frame(len, w, h);
      send_frame(5);
      rand_items += w * h;
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
  endtask

  initial begin
    win_len  = 4'd3;
    img_w    = 11'd1024;
    img_h    = 13'd1024;
    wr_pos   = 0;
    out_col  = 0;
    out_row  = 0;
    pend_cnt = 0;
    err_cnt  = 0;
    burst_left = 0;
    rand_items = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_window_lengths();
    test_size_extremes();
    test_restart();
    test_random();
    wait_drained();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  int unsigned stall_cyc = 0;
  int unsigned stall_style = 0;
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 128 == 0) stall_style <= $urandom_range(0, 2);
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (stall_cyc % 11) < 6;
    endcase
  end

  always @(posedge clk_i) begin
    out_pix_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (exp_pix_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: pixel %h frame_end %b", pixel_out, frame_end);
      end else begin
        e = exp_pix_q.pop_front();
        if (pixel_out !== e.pix || frame_end !== e.fend) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: pixel exp %h got %h, frame_end exp %b got %b",
                     e.pix, pixel_out, e.fend, frame_end);
        end
      end
    end
  end

  int unsigned quiet_cyc = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
    if (quiet_cyc >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end
endmodule
